// ===== design/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants for the fixed-size block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   localparam int NUM_BLOCKS = 1024;
   localparam int IDX_W      = 10;
   localparam int LIMIT_W    = 11;
   localparam int ADDR_W     = $clog2(NUM_BLOCKS);

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);
   localparam logic [LIMIT_W-1:0] LIMIT_CAP   = LIMIT_W'(NUM_BLOCKS < 1024 ? NUM_BLOCKS : 1024);

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_RESET = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [IDX_W-1:0] free_index;
   } req_item_type;

   typedef struct packed {
      logic             status;
      logic [IDX_W-1:0] block_index;
   } rsp_item_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_POP  = 1'b1
   } state_type;

   typedef enum logic [1:0] {
      RSEL_ZERO   = 2'd0,
      RSEL_CARVED = 2'd1,
      RSEL_HEAD   = 2'd2
   } rsp_sel_type;

   typedef struct packed {
      logic        issue_read;
      logic        push;
      logic        carve;
      logic        clear;
      logic        pop;
      logic        rsp_load;
      logic        rsp_fail;
      rsp_sel_type rsp_sel;
   } cmd_type;

   typedef struct packed {
      logic list_nonempty;
      logic can_carve;
      logic rsp_busy;
   } status_type;

endpackage

// ===== design/fbpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Sequencer: decodes each accepted item into datapath commands.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_op,
   output logic                 req_stall,
   output logic                 idle,
   input  fbpa_pkg::status_type stat,
   output fbpa_pkg::cmd_type    cmd
);
   import fbpa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.rsp_sel = RSEL_ZERO;
      req_stall = 1'b1;
      idle      = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            req_stall = stat.rsp_busy;
            if (req_valid && !stat.rsp_busy) begin
               case (req_op)
                  OP_ALLOC: begin
                     if (stat.list_nonempty) begin
                        cmd.issue_read = 1'b1;
                        state_in       = ST_POP;
                     end else if (stat.can_carve) begin
                        cmd.carve    = 1'b1;
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_sel  = RSEL_CARVED;
                     end else begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_fail = 1'b1;
                     end
                  end
                  OP_FREE: begin
                     cmd.push     = 1'b1;
                     cmd.rsp_load = 1'b1;
                  end
                  OP_RESET: begin
                     cmd.clear    = 1'b1;
                     cmd.rsp_load = 1'b1;
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            // link word is ready; wait only for room in the output register
            if (!stat.rsp_busy) begin
               cmd.pop      = 1'b1;
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = RSEL_HEAD;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/fbpa_dp.sv =====
// ----------------------------------------------------------------------------
// fbpa_dp
// Datapath: link store, list head, bump counter, limit and output register.
// ----------------------------------------------------------------------------
module fbpa_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [fbpa_pkg::IDX_W-1:0]            req_free_index,
   input  logic                                  limit_we,
   input  logic [fbpa_pkg::LIMIT_W-1:0]          limit_wdata,
   input  fbpa_pkg::cmd_type                     cmd,
   output fbpa_pkg::status_type                  stat,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output fbpa_pkg::rsp_item_type                rsp_data
);
   import fbpa_pkg::*;

   // link store entry: {tail marker, next index}
   logic [IDX_W:0] link_mem [NUM_BLOCKS];
   logic [IDX_W:0] rd_ff;

   logic [IDX_W-1:0]   head_ff;
   logic               nonempty_ff;
   logic [LIMIT_W-1:0] carved_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_ff;
   rsp_item_type       rsp_in;
   logic [LIMIT_W-1:0] eff_limit;

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         link_mem[req_free_index[ADDR_W-1:0]] <= {~nonempty_ff, head_ff};
      end
      if (cmd.issue_read) begin
         rd_ff <= link_mem[head_ff[ADDR_W-1:0]];
      end
   end

   assign eff_limit = (limit_ff > LIMIT_CAP) ? LIMIT_CAP : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         nonempty_ff <= 1'b0;
         carved_ff   <= '0;
         limit_ff    <= LIMIT_RESET;
      end else begin
         if (limit_we) begin
            limit_ff <= limit_wdata;
         end
         if (cmd.clear) begin
            head_ff     <= '0;
            nonempty_ff <= 1'b0;
            carved_ff   <= '0;
         end else if (cmd.push) begin
            head_ff     <= req_free_index;
            nonempty_ff <= 1'b1;
         end else if (cmd.pop) begin
            if (rd_ff[IDX_W]) begin
               nonempty_ff <= 1'b0;
            end else begin
               head_ff <= rd_ff[IDX_W-1:0];
            end
         end else if (cmd.carve) begin
            carved_ff <= carved_ff + LIMIT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_in.status = cmd.rsp_fail;
      case (cmd.rsp_sel)
         RSEL_CARVED: rsp_in.block_index = carved_ff[IDX_W-1:0];
         RSEL_HEAD:   rsp_in.block_index = head_ff;
         default:     rsp_in.block_index = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_ff;
   assign stat.list_nonempty = nonempty_ff;
   assign stat.can_carve     = (carved_ff < eff_limit);
   assign stat.rsp_busy      = rsp_valid_ff && rsp_stall;

endmodule

// ===== design/fixed_block_pool_allocator_core.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// Pool allocator for fixed-size blocks: LIFO free list plus bump counter.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/stall    | req_data  (op, free_index)
//  rsp     | out | rsp_valid/stall    | rsp_data  (status, block_index)
//  csr     | in  | csr_valid/ready    | csr_data  (block_limit)
//
//  Allocate from the free list: registered link store read of the head entry
//  (state ST_POP), input stalled while it waits. Allocate from the bump
//  counter, free, reset: loaded straight into the output register. One item in flight; a result waiting on
//  rsp_stall stalls the input, and the next item is taken in the cycle the
//  waiting result leaves. Synchronous reset empties the pool and sets the
//  limit to 1024; link store contents are not cleared.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  fbpa_pkg::req_item_type         req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output fbpa_pkg::rsp_item_type         rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fbpa_pkg::LIMIT_W-1:0]   csr_data
);
   import fbpa_pkg::*;

   cmd_type    cmd;
   status_type stat;
   logic       idle;

   assign csr_ready = idle;

   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .idle      (idle),
      .stat      (stat),
      .cmd       (cmd)
   );

   fbpa_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_free_index (req_data.free_index),
      .limit_we       (csr_valid && csr_ready),
      .limit_wdata    (csr_data),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data)
   );

endmodule
